// File: rtl/tssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_pkg: shared types and constants of the SYN signature matcher
// Table geometry, function codes, the stored entry layout and the compare
// result that travels from the compare stage to the selection logic.
// ----------------------------------------------------------------------------
package tssm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int FUNC_W      = 2;
    localparam int SCORE_W     = 17;
    localparam int WTYPE_W     = 2;
    localparam int CTL_W       = 10;
    localparam int OUT_IDX_W   = 6;

    localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

    localparam logic [SCORE_W-1:0] NO_MATCH_SCORE = 17'd100000;

    // wildcard bits of the entry control word
    localparam int WC_MSS    = 0;
    localparam int WC_WSCALE = 1;
    localparam int WC_TTL    = 2;
    localparam int WC_IPOL   = 3;
    localparam int WC_HASH   = 4;
    localparam int WC_EOL    = 5;
    localparam int WC_QUIRKS = 6;
    localparam int CTL_SPECIFIC = 9;

    localparam logic [WTYPE_W-1:0] WTYPE_MULT  = 2'd1;
    localparam logic [WTYPE_W-1:0] WTYPE_EXACT = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [31:0]        layout_hash;
        logic [31:0]        quirks;
        logic [7:0]         eol_padding;
        logic [7:0]         ipopt_bytes;
        logic [7:0]         ttl;
        logic [15:0]        mss;
        logic [15:0]        win;
        logic [7:0]         wscale;
        logic               ack_flag;
    } t_pkt;

    typedef struct packed {
        t_pkt               fp;
        logic [CTL_W-1:0]   control;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic               valid;
        t_idx               idx;
        logic               hit;
        logic               specific;
        logic [SCORE_W-1:0] score;
        logic [WTYPE_W-1:0] wnd_kind;
    } t_cmp_res;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] best_index;
        logic [WTYPE_W-1:0]   best_wnd_kind;
        logic [SCORE_W-1:0]   best_score;
        logic                 matched;
        logic                 table_full;
    } t_result;

    // low bits of a table index, as reported on the result channel
    function automatic logic [OUT_IDX_W-1:0] out_index(input t_idx idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

// File: rtl/tssm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_in_if / tssm_out_if: valid-ready channels of the signature matcher
// Request beats carry a fingerprint or an entry; result beats the outcome.
// ----------------------------------------------------------------------------
interface tssm_in_if;
    logic                          valid;
    logic                          ready;
    logic [tssm_pkg::FUNC_W-1:0]   func;
    logic [31:0]                   layout_hash;
    logic [31:0]                   quirks;
    logic [7:0]                    eol_padding;
    logic [7:0]                    ipopt_bytes;
    logic [7:0]                    ttl;
    logic [15:0]                   mss;
    logic [15:0]                   win;
    logic [7:0]                    wscale;
    logic                          ack_flag;
    logic [tssm_pkg::CTL_W-1:0]    entry_control;
    logic [tssm_pkg::SCORE_W-1:0]  entry_score;

    modport source (output valid, func, layout_hash, quirks, eol_padding, ipopt_bytes, ttl,
                    mss, win, wscale, ack_flag, entry_control, entry_score,
                    input ready);
    modport sink   (input valid, func, layout_hash, quirks, eol_padding, ipopt_bytes, ttl,
                    mss, win, wscale, ack_flag, entry_control, entry_score,
                    output ready);
endinterface

interface tssm_out_if;
    logic                            valid;
    logic                            ready;
    logic [tssm_pkg::OUT_IDX_W-1:0]  best_index;
    logic [tssm_pkg::WTYPE_W-1:0]    best_wnd_kind;
    logic [tssm_pkg::SCORE_W-1:0]    best_score;
    logic                            matched;
    logic                            table_full;

    modport source (output valid, best_index, best_wnd_kind, best_score, matched,
                    table_full, input ready);
    modport sink   (input valid, best_index, best_wnd_kind, best_score, matched,
                    table_full, output ready);
endinterface

// File: rtl/tssm_sig_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_sig_mem: signature table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tssm_sig_mem (
    input  logic              i_clk,
    input  logic              i_we,
    input  tssm_pkg::t_idx    i_waddr,
    input  tssm_pkg::t_entry  i_wdata,
    input  logic              i_re,
    input  tssm_pkg::t_idx    i_raddr,
    output tssm_pkg::t_entry  o_rdata
);

    tssm_pkg::t_entry r_mem [tssm_pkg::TABLE_DEPTH];
    tssm_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tssm_entry_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_entry_cmp: field compare of one table entry against the fingerprint
// Registers the hit flag together with the entry's index, class and score.
// ----------------------------------------------------------------------------
module tssm_entry_cmp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  tssm_pkg::t_idx      i_idx,
    input  tssm_pkg::t_entry    i_ent,
    input  tssm_pkg::t_pkt      i_pkt,
    output tssm_pkg::t_cmp_res  o_res
);

    logic [6:0]                    wc;
    logic [tssm_pkg::WTYPE_W-1:0]  wtype;
    logic [31:0]                   win_prod;
    logic                          fail;
    tssm_pkg::t_cmp_res            r_res;

    assign wc       = i_ent.control[6:0];
    assign wtype    = i_ent.control[8:7];
    assign win_prod = 32'(i_pkt.mss) * 32'(i_ent.fp.win);

    always_comb begin
        fail = 1'b0;
        if (i_ent.fp.layout_hash != i_pkt.layout_hash && !wc[tssm_pkg::WC_HASH]) fail = 1'b1;
        if (i_ent.fp.quirks != i_pkt.quirks && !wc[tssm_pkg::WC_QUIRKS])        fail = 1'b1;
        if (i_ent.fp.eol_padding != i_pkt.eol_padding && !wc[tssm_pkg::WC_EOL]) fail = 1'b1;
        if (i_ent.fp.ipopt_bytes != i_pkt.ipopt_bytes && !wc[tssm_pkg::WC_IPOL]) fail = 1'b1;
        // entry TTL is a ceiling: fail only when the packet exceeds it
        if (i_ent.fp.ttl < i_pkt.ttl && !wc[tssm_pkg::WC_TTL])                  fail = 1'b1;
        if (i_ent.fp.mss != i_pkt.mss && !wc[tssm_pkg::WC_MSS])                 fail = 1'b1;
        if (wtype == tssm_pkg::WTYPE_MULT && win_prod != {16'd0, i_pkt.win})    fail = 1'b1;
        if (wtype == tssm_pkg::WTYPE_EXACT && i_ent.fp.win != i_pkt.win)        fail = 1'b1;
        if (i_ent.fp.wscale != i_pkt.wscale && !wc[tssm_pkg::WC_WSCALE])        fail = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= i_vld;
        end
        r_res.idx      <= i_idx;
        r_res.hit      <= !fail && (i_ent.fp.ack_flag == i_pkt.ack_flag);
        r_res.specific <= i_ent.control[tssm_pkg::CTL_SPECIFIC];
        r_res.score    <= i_ent.score;
        r_res.wnd_kind <= wtype;
    end

    assign o_res = r_res;

endmodule

// File: rtl/tcp_syn_signature_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_signature_matcher: passive TCP SYN fingerprint table and classifier
// Appends signatures to a table, clears it, and classifies fingerprints.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries request beats: func selects classify, append or clear. For an
//   append, the fingerprint fields plus entry_control and entry_score form the
//   new entry; for a classify they are the packet fingerprint.
//   o_out carries exactly one result beat per request beat, in order.
// Flow:
//   Append, clear and the unused code need no scan; the result is
//   registered and shows on o_out the cycle after the request beat.
//   A classify walks the loaded entries (at most 64) through the table's single
//   read port, one entry per cycle, then drains a two-stage read/compare pipe;
//   an empty table skips the scan.
//   Only one request is in flight; the next is taken once the scan finishes.
// Reset:
//   Synchronous active-low i_rst_n empties the table (entry count to zero) and
//   drops any pending result. Table contents need no clearing.
// Stalls:
//   A held result blocks nothing but new appends, clears and unused codes; a
//   finished classify waits in place until the result register frees up.
// ----------------------------------------------------------------------------
module tcp_syn_signature_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tssm_in_if.sink    i_in,
    tssm_out_if.source o_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                     r_state;
    tssm_pkg::t_cnt                 r_count;
    tssm_pkg::t_cnt                 r_n;
    tssm_pkg::t_cnt                 r_ptr;
    tssm_pkg::t_pkt                 r_pkt;
    logic                           r_rd_vld;
    tssm_pkg::t_idx                 r_rd_idx;

    // running best of the scan
    tssm_pkg::t_idx                 r_best_idx;
    logic [tssm_pkg::SCORE_W-1:0]   r_best_score;
    logic [tssm_pkg::WTYPE_W-1:0]   r_best_wt;
    logic [tssm_pkg::WTYPE_W-1:0]   r_wt0;
    logic                           r_found;
    logic                           r_spec;

    logic                           r_out_valid;
    tssm_pkg::t_result              r_out;

    logic                           slot_free;
    logic                           in_is_cls;
    logic                           in_fire;
    logic                           full;
    logic                           we;
    logic                           out_load;
    tssm_pkg::t_result              idle_res;
    tssm_pkg::t_entry               wdata;
    tssm_pkg::t_entry               rdata;
    tssm_pkg::t_pkt                 in_pkt;
    tssm_pkg::t_cmp_res             cres;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign in_is_cls  = (i_in.func == tssm_pkg::FUNC_CLASSIFY);
    // classify may start while a result waits; other requests need the slot
    assign i_in.ready = (r_state == ST_IDLE) && (in_is_cls || slot_free);
    assign in_fire    = i_in.valid && i_in.ready;
    assign full       = (r_count >= tssm_pkg::CNT_W'(tssm_pkg::TABLE_DEPTH));

    // load the result register for an append, clear or unused code, or a finished scan
    assign out_load   = (in_fire && !in_is_cls) || ((r_state == ST_FINISH) && slot_free);

    // result of an append, clear or unused code: only a dropped append flags
    always_comb begin
        idle_res            = '0;
        idle_res.table_full = (i_in.func == tssm_pkg::FUNC_APPEND) && full;
    end

    assign in_pkt.layout_hash = i_in.layout_hash;
    assign in_pkt.quirks      = i_in.quirks;
    assign in_pkt.eol_padding = i_in.eol_padding;
    assign in_pkt.ipopt_bytes = i_in.ipopt_bytes;
    assign in_pkt.ttl         = i_in.ttl;
    assign in_pkt.mss         = i_in.mss;
    assign in_pkt.win         = i_in.win;
    assign in_pkt.wscale      = i_in.wscale;
    assign in_pkt.ack_flag    = i_in.ack_flag;

    assign wdata.fp      = in_pkt;
    assign wdata.control = i_in.entry_control;
    assign wdata.score   = i_in.entry_score;

    // write the new entry at the fill position; drop it when the table is full
    assign we = in_fire && (i_in.func == tssm_pkg::FUNC_APPEND) && !full;

    tssm_sig_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[tssm_pkg::IDX_W-1:0]),
        .i_wdata (wdata),
        .i_re    (r_state == ST_SCAN),
        .i_raddr (r_ptr[tssm_pkg::IDX_W-1:0]),
        .o_rdata (rdata)
    );

    tssm_entry_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_idx   (r_rd_idx),
        .i_ent   (rdata),
        .i_pkt   (r_pkt),
        .o_res   (cres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            // track which read is in flight, aligned with the memory output
            r_rd_vld <= (r_state == ST_SCAN);
            r_rd_idx <= r_ptr[tssm_pkg::IDX_W-1:0];

            // hold the result beat until taken; a new one may replace it at once
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        case (i_in.func)
                            tssm_pkg::FUNC_CLASSIFY: begin
                                r_pkt        <= in_pkt;
                                r_n          <= r_count;
                                r_ptr        <= '0;
                                r_best_idx   <= '0;
                                r_best_score <= tssm_pkg::NO_MATCH_SCORE;
                                r_best_wt    <= '0;
                                r_wt0        <= '0;
                                r_found      <= 1'b0;
                                r_spec       <= 1'b0;
                                r_state      <= (r_count == '0) ? ST_FINISH : ST_SCAN;
                            end
                            tssm_pkg::FUNC_APPEND: begin
                                if (!full) begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_out <= idle_res;
                            end
                            tssm_pkg::FUNC_CLEAR: begin
                                r_count <= '0;
                                r_out   <= idle_res;
                            end
                            default: begin
                                r_out <= idle_res;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // issue one read per cycle; stop after the last loaded entry
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == tssm_pkg::CNT_W'(r_n - 1'b1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_rd_vld && !cres.valid) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (slot_free) begin
                        r_out.best_index    <= tssm_pkg::out_index(r_best_idx);
                        r_out.best_wnd_kind <= r_found ? r_best_wt :
                                               ((r_n != '0) ? r_wt0 : '0);
                        r_out.best_score    <= r_best_score;
                        r_out.matched       <= r_found;
                        r_out.table_full    <= 1'b0;
                        r_state             <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // selection: first specific hit freezes the result; otherwise
            // keep the strictly lowest general score (earlier entry on ties)
            if (cres.valid && !r_spec) begin
                if (cres.idx == '0) begin
                    r_wt0 <= cres.wnd_kind;
                end
                if (cres.hit && cres.specific) begin
                    r_best_idx   <= cres.idx;
                    r_best_score <= '0;
                    r_best_wt    <= cres.wnd_kind;
                    r_found      <= 1'b1;
                    r_spec       <= 1'b1;
                end else if (cres.hit && (cres.score < r_best_score)) begin
                    r_best_idx   <= cres.idx;
                    r_best_score <= cres.score;
                    r_best_wt    <= cres.wnd_kind;
                    r_found      <= 1'b1;
                end
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.best_index    = r_out.best_index;
    assign o_out.best_wnd_kind = r_out.best_wnd_kind;
    assign o_out.best_score    = r_out.best_score;
    assign o_out.matched       = r_out.matched;
    assign o_out.table_full    = r_out.table_full;

endmodule
